FILE: design/prq_pkg.sv
`default_nettype none

package prq_pkg;

    // Sizing of the queue
    localparam int THREADS = 64;
    localparam int LEVELS  = 32;

    localparam int TID_W = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    // Fixed field widths of the request and response beats
    localparam int ACTION_W    = 2;
    localparam int THREAD_ID_W = 6;
    localparam int PRIO_W      = 5;
    localparam int CPU_ID_W    = 3;
    localparam int STATUS_W    = 2;
    localparam int AFF_W       = 2;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BLOCK = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

    // Affinity codes
    localparam logic [AFF_W-1:0] AFF_NEVER = 2'd0;
    localparam logic [AFF_W-1:0] AFF_SAME  = 2'd1;
    localparam logic [AFF_W-1:0] AFF_OTHER = 2'd2;

    // Commands into the level table
    typedef struct packed {
        logic             push_en;
        logic [LVL_W-1:0] push_lvl;
        logic [TID_W-1:0] push_tid;
        logic             clr_en;
        logic [LVL_W-1:0] clr_lvl;
        logic             adv_en;
        logic [LVL_W-1:0] adv_lvl;
        logic [TID_W-1:0] adv_head;
    } lvl_cmd_t;

    // Status out of the level table
    typedef struct packed {
        logic             any;
        logic [LVL_W-1:0] top_lvl;
        logic [TID_W-1:0] top_head;
        logic             top_single;
        logic             q_nonempty;
        logic [TID_W-1:0] q_tail;
    } lvl_st_t;

    // Highest set bit of a 32-bit map by halving; 0 when the map is empty
    function automatic logic [4:0] hi_level(input logic [31:0] m);
        logic [4:0]  r;
        logic [15:0] a;
        logic [7:0]  b;
        logic [3:0]  c;
        logic [1:0]  d;
        r[4] = |m[31:16];
        a    = r[4] ? m[31:16] : m[15:0];
        r[3] = |a[15:8];
        b    = r[3] ? a[15:8] : a[7:0];
        r[2] = |b[7:4];
        c    = r[2] ? b[7:4] : b[3:0];
        r[1] = |c[3:2];
        d    = r[1] ? c[3:2] : c[1:0];
        r[0] = d[1];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/prq_req_if.sv
`default_nettype none

interface prq_req_if;
    logic                          valid;
    logic                          ready;
    logic [prq_pkg::ACTION_W-1:0]    action;
    logic [prq_pkg::THREAD_ID_W-1:0] thread_id;
    logic [prq_pkg::PRIO_W-1:0]      priority_req;
    logic [prq_pkg::CPU_ID_W-1:0]    cpu_id;

    modport source (output valid, action, thread_id, priority_req, cpu_id, input ready);
    modport sink   (input valid, action, thread_id, priority_req, cpu_id, output ready);
endinterface

`default_nettype wire

FILE: design/prq_rsp_if.sv
`default_nettype none

interface prq_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [prq_pkg::STATUS_W-1:0]    status;
    logic [prq_pkg::THREAD_ID_W-1:0] chosen_thread;
    logic [prq_pkg::PRIO_W-1:0]      chosen_priority;
    logic [prq_pkg::AFF_W-1:0]       affinity;

    modport source (output valid, status, chosen_thread, chosen_priority, affinity,
                    input ready);
    modport sink   (input valid, status, chosen_thread, chosen_priority, affinity,
                    output ready);
endinterface

`default_nettype wire

FILE: design/priority_ready_queue.sv
// Multilevel FIFO ready queue for a thread scheduler. Each priority level
// holds a linked FIFO of thread slots; a bitmap marks the levels that are
// not empty. A push (action 0) marks the thread ready and appends it to the
// tail of its level unless it is already queued (status 1). A block
// (action 1) clears the ready mark and leaves the entry queued. A pop
// (action 2) walks the head of the highest non-empty level, dropping entries
// that are no longer ready, and returns the first ready thread with its level
// and CPU affinity (0 never ran, 1 same CPU, 2 other CPU); it records the
// asking CPU as the thread's last CPU. An empty pop returns status 2.
// Timing: the block takes one request beat at a time. A push, a block or an
// empty pop passes through EXEC or POP_SEL and then RESP; a pop steps through
// POP_SEL and POP_CHK for each queue entry that it examines, since each step
// of the walk waits on the registered read of the next-link memory. A result
// sits in the output register, so the next request is taken while that result
// waits; the block stalls only when a second result is ready and the output
// register is still full. No clearing pass is needed after reset.
`default_nettype none

module priority_ready_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    prq_req_if.sink   req,
    prq_rsp_if.source rsp
);
    import prq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_SEL,
        S_POP_CHK,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    // Captured request
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [TID_W-1:0]    tid_reg, tid_next;
    logic                tid_ok_reg, tid_ok_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [CPU_ID_W-1:0] cpu_reg, cpu_next;

    // Per-thread flags
    logic [THREADS-1:0] queued_reg, queued_next;
    logic [THREADS-1:0] ready_reg, ready_next;
    logic [THREADS-1:0] ran_reg, ran_next;

    // Walk state
    logic [LVL_W-1:0] pop_lvl_reg, pop_lvl_next;
    logic [TID_W-1:0] pop_tid_reg, pop_tid_next;
    logic             pop_last_reg, pop_last_next;
    logic             pop_ready_reg, pop_ready_next;
    logic             pop_ran_reg, pop_ran_next;

    // Pending result and output register
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [THREAD_ID_W-1:0] res_tid_reg, res_tid_next;
    logic [PRIO_W-1:0]      res_prio_reg, res_prio_next;
    logic [AFF_W-1:0]       res_aff_reg, res_aff_next;
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [THREAD_ID_W-1:0] out_tid_reg, out_tid_next;
    logic [PRIO_W-1:0]      out_prio_reg, out_prio_next;
    logic [AFF_W-1:0]       out_aff_reg, out_aff_next;

    // Level table
    lvl_cmd_t lvl_cmd;
    lvl_st_t  lvl_st;

    // Next-link and last-CPU memories
    logic                link_we;
    logic [TID_W-1:0]    link_waddr;
    logic [TID_W-1:0]    link_wdata;
    logic [TID_W-1:0]    link_rdata;
    logic                cpu_we;
    logic [CPU_ID_W-1:0] cpu_rdata;

    prq_lvl u_lvl (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (lvl_cmd),
        .st    (lvl_st)
    );

    // Both memories are read at the head of the top level; data lands in POP_CHK
    prq_ram #(
        .WIDTH (TID_W),
        .DEPTH (THREADS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (lvl_st.top_head),
        .rdata (link_rdata)
    );

    prq_ram #(
        .WIDTH (CPU_ID_W),
        .DEPTH (THREADS)
    ) u_cpu_ram (
        .clk   (clk),
        .we    (cpu_we),
        .waddr (pop_tid_reg),
        .wdata (cpu_reg),
        .raddr (lvl_st.top_head),
        .rdata (cpu_rdata)
    );

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.chosen_thread   = out_tid_reg;
    assign rsp.chosen_priority = out_prio_reg;
    assign rsp.affinity        = out_aff_reg;

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        tid_next        = tid_reg;
        tid_ok_next     = tid_ok_reg;
        lvl_next        = lvl_reg;
        cpu_next        = cpu_reg;
        queued_next     = queued_reg;
        ready_next      = ready_reg;
        ran_next        = ran_reg;
        pop_lvl_next    = pop_lvl_reg;
        pop_tid_next    = pop_tid_reg;
        pop_last_next   = pop_last_reg;
        pop_ready_next  = pop_ready_reg;
        pop_ran_next    = pop_ran_reg;
        res_status_next = res_status_reg;
        res_tid_next    = res_tid_reg;
        res_prio_next   = res_prio_reg;
        res_aff_next    = res_aff_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_tid_next    = out_tid_reg;
        out_prio_next   = out_prio_reg;
        out_aff_next    = out_aff_reg;

        lvl_cmd          = '0;
        lvl_cmd.push_lvl = lvl_reg;
        lvl_cmd.push_tid = tid_reg;
        link_we          = 1'b0;
        link_waddr       = lvl_st.q_tail;
        link_wdata       = tid_reg;
        cpu_we           = 1'b0;

        // Drop the output beat once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next    = req.action;
                    tid_next    = TID_W'(req.thread_id);
                    tid_ok_next = (32'(req.thread_id) < 32'(THREADS));
                    // Saturate an out-of-range level to the top one
                    lvl_next    = (32'(req.priority_req) >= 32'(LEVELS)) ?
                                  LVL_W'(LEVELS - 1) : LVL_W'(req.priority_req);
                    cpu_next        = req.cpu_id;
                    res_status_next = ST_DONE;
                    res_tid_next    = '0;
                    res_prio_next   = '0;
                    res_aff_next    = AFF_NEVER;
                    case (req.action)
                        ACT_PUSH:  state_next = S_EXEC;
                        ACT_BLOCK: state_next = S_EXEC;
                        ACT_POP:   state_next = S_POP_SEL;
                        default:   state_next = S_RESP;
                    endcase
                end
            end

            S_EXEC:
            begin
                if (tid_ok_reg)
                begin
                    if (act_reg == ACT_PUSH)
                    begin
                        ready_next[tid_reg] = 1'b1;
                        if (queued_reg[tid_reg])
                        begin
                            res_status_next = ST_QUEUED;
                        end
                        else
                        begin
                            // Append at the tail; link from the old tail if any
                            queued_next[tid_reg] = 1'b1;
                            lvl_cmd.push_en      = 1'b1;
                            link_we              = lvl_st.q_nonempty;
                        end
                    end
                    else
                    begin
                        ready_next[tid_reg] = 1'b0;
                    end
                end
                state_next = S_RESP;
            end

            S_POP_SEL:
            begin
                if (!lvl_st.any)
                begin
                    res_status_next = ST_EMPTY;
                    state_next      = S_RESP;
                end
                else
                begin
                    // Unqueue the head; retire the level if this was its last entry
                    pop_lvl_next   = lvl_st.top_lvl;
                    pop_tid_next   = lvl_st.top_head;
                    pop_last_next  = lvl_st.top_single;
                    pop_ready_next = ready_reg[lvl_st.top_head];
                    pop_ran_next   = ran_reg[lvl_st.top_head];
                    queued_next[lvl_st.top_head] = 1'b0;
                    lvl_cmd.clr_en  = lvl_st.top_single;
                    lvl_cmd.clr_lvl = lvl_st.top_lvl;
                    state_next      = S_POP_CHK;
                end
            end

            S_POP_CHK:
            begin
                // Advance the head to the next link now that it has been read
                lvl_cmd.adv_en   = !pop_last_reg;
                lvl_cmd.adv_lvl  = pop_lvl_reg;
                lvl_cmd.adv_head = link_rdata;
                if (pop_ready_reg)
                begin
                    if (!pop_ran_reg)
                    begin
                        res_aff_next = AFF_NEVER;
                    end
                    else if (cpu_rdata == cpu_reg)
                    begin
                        res_aff_next = AFF_SAME;
                    end
                    else
                    begin
                        res_aff_next = AFF_OTHER;
                    end
                    cpu_we                = 1'b1;
                    ran_next[pop_tid_reg] = 1'b1;
                    res_status_next       = ST_DONE;
                    res_tid_next          = THREAD_ID_W'(pop_tid_reg);
                    res_prio_next         = PRIO_W'(pop_lvl_reg);
                    state_next            = S_RESP;
                end
                else
                begin
                    // Stale entry: dropped, keep walking
                    state_next = S_POP_SEL;
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_tid_next    = res_tid_reg;
                    out_prio_next   = res_prio_reg;
                    out_aff_next    = res_aff_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            queued_reg    <= '0;
            ready_reg     <= '0;
            ran_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            queued_reg    <= queued_next;
            ready_reg     <= ready_next;
            ran_reg       <= ran_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        tid_reg        <= tid_next;
        tid_ok_reg     <= tid_ok_next;
        lvl_reg        <= lvl_next;
        cpu_reg        <= cpu_next;
        pop_lvl_reg    <= pop_lvl_next;
        pop_tid_reg    <= pop_tid_next;
        pop_last_reg   <= pop_last_next;
        pop_ready_reg  <= pop_ready_next;
        pop_ran_reg    <= pop_ran_next;
        res_status_reg <= res_status_next;
        res_tid_reg    <= res_tid_next;
        res_prio_reg   <= res_prio_next;
        res_aff_reg    <= res_aff_next;
        out_status_reg <= out_status_next;
        out_tid_reg    <= out_tid_next;
        out_prio_reg   <= out_prio_next;
        out_aff_reg    <= out_aff_next;
    end

`ifndef NO_ASSERTIONS
    // An accepted request always moves the sequencer out of idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != S_IDLE)
        else $error("request accepted but sequencer stayed idle");

    // With every level empty, no thread may still be marked queued
    a_empty_unqueued: assert property (@(posedge clk) disable iff (!rst_n)
        !lvl_st.any |-> queued_reg == '0)
        else $error("queued thread with all levels empty");

    // The entry under check has already been unqueued
    a_chk_unqueued: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP_CHK |-> !queued_reg[pop_tid_reg])
        else $error("popped entry still marked queued");

    // A thread chosen by a pop is marked as having run
    a_chosen_ran: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP_CHK && pop_ready_reg |=> ran_reg[pop_tid_reg])
        else $error("chosen thread not marked as run");
`endif

endmodule

`default_nettype wire

FILE: design/prq_ram.sv
`default_nettype none

module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/prq_lvl.sv
`default_nettype none

module prq_lvl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire prq_pkg::lvl_cmd_t cmd,
    output prq_pkg::lvl_st_t       st
);
    import prq_pkg::*;

    logic [LEVELS-1:0] nonempty_reg;
    logic [LEVELS-1:0] nonempty_next;
    logic [TID_W-1:0]  head_reg [LEVELS];
    logic [TID_W-1:0]  tail_reg [LEVELS];
    logic [LVL_W-1:0]  top_lvl;

    // Pick the highest non-empty level
    assign top_lvl = LVL_W'(hi_level(32'(nonempty_reg)));

    always_comb
    begin
        st.any        = |nonempty_reg;
        st.top_lvl    = top_lvl;
        st.top_head   = head_reg[top_lvl];
        st.top_single = (head_reg[top_lvl] == tail_reg[top_lvl]);
        st.q_nonempty = nonempty_reg[cmd.push_lvl];
        st.q_tail     = tail_reg[cmd.push_lvl];
    end

    always_comb
    begin
        nonempty_next = nonempty_reg;
        if (cmd.push_en)
        begin
            nonempty_next[cmd.push_lvl] = 1'b1;
        end
        if (cmd.clr_en)
        begin
            nonempty_next[cmd.clr_lvl] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg <= '0;
        end
        else
        begin
            nonempty_reg <= nonempty_next;
        end
    end

    // Head and tail entries mean something only while the level bit is set
    always_ff @(posedge clk)
    begin
        if (cmd.push_en)
        begin
            if (!nonempty_reg[cmd.push_lvl])
            begin
                head_reg[cmd.push_lvl] <= cmd.push_tid;
            end
            tail_reg[cmd.push_lvl] <= cmd.push_tid;
        end
        if (cmd.adv_en)
        begin
            head_reg[cmd.adv_lvl] <= cmd.adv_head;
        end
    end

endmodule

`default_nettype wire

FILE: test/prq_schedule_checker.sv
`timescale 1ns / 1ps

module prq_schedule_checker
    import prq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    prq_req_if   req,
    prq_rsp_if   rsp,
    output int   fail_count,
    output int   picks_outstanding
);

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [THREAD_ID_W-1:0] thread;
        logic [PRIO_W-1:0]      prio;
        logic [AFF_W-1:0]       affinity;
    } pick_t;

    typedef struct packed {
        logic [LVL_W-1:0]    lvl;
        logic [CPU_ID_W-1:0] prev_cpu;
        logic                ran;
        logic                ready;
        logic                queued;
    } slot_t;

    logic [TID_W-1:0]  head_of [LEVELS];
    logic [TID_W-1:0]  tail_of [LEVELS];
    logic [TID_W-1:0]  next_of [THREADS];
    logic [LEVELS-1:0] occupied;
    slot_t             slot [THREADS];
    pick_t             picks_due [$];

    // Apply one request beat to the shadow queue and return the result it must produce.
    function automatic pick_t resolve_request(input logic [ACTION_W-1:0]    act,
                                              input logic [THREAD_ID_W-1:0] tid,
                                              input logic [PRIO_W-1:0]      prio,
                                              input logic [CPU_ID_W-1:0]    cpu);
        pick_t            r;
        slot_t            f;
        logic [LVL_W-1:0] lvl;
        logic [LVL_W-1:0] top;
        logic [TID_W-1:0] t;
        bit               found;
        int               n;
        int               p;
        r     = '0;
        found = 1'b0;
        top   = '0;
        lvl   = (int'(prio) >= LEVELS) ? LVL_W'(LEVELS - 1) : LVL_W'(prio);
        case (act)
            ACT_PUSH:
            begin
                if (int'(tid) < THREADS)
                begin
                    f = slot[tid];
                    f.ready = 1'b1;
                    if (f.queued)
                        r.status = ST_QUEUED;
                    else
                    begin
                        f.queued = 1'b1;
                        f.lvl    = lvl;
                        if (occupied[lvl])
                            next_of[tail_of[lvl]] = TID_W'(tid);
                        else
                            head_of[lvl] = TID_W'(tid);
                        tail_of[lvl]  = TID_W'(tid);
                        occupied[lvl] = 1'b1;
                    end
                    slot[tid] = f;
                end
            end
            ACT_BLOCK:
            begin
                if (int'(tid) < THREADS)
                    slot[tid].ready = 1'b0;
            end
            ACT_POP:
            begin
                r.status = ST_EMPTY;
                n = 0;
                while (!found && occupied != '0 && n <= THREADS)
                begin
                    for (p = 0; p < LEVELS; p++)
                        if (occupied[p])
                            top = LVL_W'(p);
                    t = head_of[top];
                    if (head_of[top] == tail_of[top])
                        occupied[top] = 1'b0;
                    else
                        head_of[top] = next_of[t];
                    f = slot[t];
                    f.queued = 1'b0;
                    if (f.ready)
                    begin
                        if (!f.ran)
                            r.affinity = AFF_NEVER;
                        else if (f.prev_cpu == cpu)
                            r.affinity = AFF_SAME;
                        else
                            r.affinity = AFF_OTHER;
                        f.ran      = 1'b1;
                        f.prev_cpu = cpu;
                        r.status   = ST_DONE;
                        r.thread   = THREAD_ID_W'(t);
                        r.prio     = PRIO_W'(top);
                        found      = 1'b1;
                    end
                    slot[t] = f;
                    n++;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pick_t want;
        int    i;
        if (!rst_n)
        begin
            occupied = '0;
            for (i = 0; i < LEVELS; i++)
            begin
                head_of[i] = '0;
                tail_of[i] = '0;
            end
            for (i = 0; i < THREADS; i++)
            begin
                next_of[i] = '0;
                slot[i]    = '0;
            end
            picks_due.delete();
            fail_count        = 0;
            picks_outstanding = 0;
        end
        else
        begin
            // A result can never belong to the request taken at the same edge.
            if (rsp.valid && rsp.ready)
            begin
                if (picks_due.size() == 0)
                begin
                    $error("result beat with no result pending: status %0d thread %0d",
                           rsp.status, rsp.chosen_thread);
                    fail_count++;
                end
                else
                begin
                    want = picks_due.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.chosen_thread !== want.thread)
                    begin
                        $error("chosen_thread: expected %0d, got %0d",
                               want.thread, rsp.chosen_thread);
                        fail_count++;
                    end
                    if (rsp.chosen_priority !== want.prio)
                    begin
                        $error("chosen_priority: expected %0d, got %0d",
                               want.prio, rsp.chosen_priority);
                        fail_count++;
                    end
                    if (rsp.affinity !== want.affinity)
                    begin
                        $error("affinity: expected %0d, got %0d", want.affinity, rsp.affinity);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                picks_due.push_back(resolve_request(req.action, req.thread_id,
                                                    req.priority_req, req.cpu_id));
            picks_outstanding = picks_due.size();
        end
    end

endmodule

FILE: test/priority_ready_queue_test.sv
`timescale 1ns / 1ps

module priority_ready_queue_test;
    import prq_pkg::*;

    // Action code 3 has no function in the block; it must leave the queue untouched.
    localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

    // Cycles without any accepted beat before the run is declared hung. The worst
    // legal gap is a long receiver hold plus a full 64-entry pop walk plus random stalls.
    localparam int WATCHDOG_LIMIT = 3000;
    // Receiver hold-off used to fill the block and stall its request side.
    localparam int HOLD_CYCLES    = 150;
    // Drain time after the last result: longer than the slowest pop walk.
    localparam int DRAIN_CYCLES   = 200;
    // Random request beats per idling phase.
    localparam int BEATS_PER_PHASE = 667;

    logic clk;
    logic rst_n;
    int   phase;
    int   fail_count;
    int   picks_outstanding;
    int   idle_cycles;

    prq_req_if req_ch ();
    prq_rsp_if rsp_ch ();

    priority_ready_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    prq_schedule_checker schedule_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .req               (req_ch),
        .rsp               (rsp_ch),
        .fail_count        (fail_count),
        .picks_outstanding (picks_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Idle percentage per phase: sender light and receiver heavy, then swapped,
    // then no idling at all.
    function automatic int idle_pct(input bit sender);
        case (phase)
            0:       return sender ? 28 : 59;
            1:       return sender ? 59 : 28;
            default: return 0;
        endcase
    endfunction

    // Offer one request beat. Enter and leave on a falling edge; valid stays high
    // into the next call unless that call starts with idle cycles.
    task automatic send_beat(input logic [ACTION_W-1:0]    act,
                             input logic [THREAD_ID_W-1:0] tid,
                             input logic [PRIO_W-1:0]      prio,
                             input logic [CPU_ID_W-1:0]    cpu);
        while ($urandom_range(99) < idle_pct(1'b1))
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.action       = act;
        req_ch.thread_id    = tid;
        req_ch.priority_req = prio;
        req_ch.cpu_id       = cpu;
        // Hold the beat until the block takes it.
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // One random beat. Pushes favor a few low levels so that FIFOs get deep and
    // pops walk over stale entries; the other levels keep every priority bit moving.
    // Report whether the beat does real work, so that no-op beats do not count.
    task automatic send_random_beat(output bit counted);
        logic [ACTION_W-1:0]    act;
        logic [THREAD_ID_W-1:0] tid;
        logic [PRIO_W-1:0]      prio;
        logic [CPU_ID_W-1:0]    cpu;
        int                     pick;
        tid  = THREAD_ID_W'($urandom_range(63));
        prio = $urandom_range(1) ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom_range(31));
        cpu  = CPU_ID_W'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 45)
            act = ACT_PUSH;
        else if (pick < 60)
            act = ACT_BLOCK;
        else if (pick < 95)
            act = ACT_POP;
        else
            act = ACT_NOP;
        counted = (act != ACT_NOP);
        send_beat(act, tid, prio, cpu);
    endtask

    // Result side: random stalls per phase, plus a long hold at each phase change
    // while the sender keeps offering, so the block backs up and drops req.ready.
    initial
    begin : receiver
        int seen_phase;
        int hold;
        rsp_ch.ready = 1'b0;
        seen_phase   = 0;
        hold         = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (phase != seen_phase)
            begin
                seen_phase = phase;
                hold       = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold--;
            end
            else
                rsp_ch.ready = ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    // Watchdog: count cycles with no accepted beat on either channel.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int stage;
        int issued;
        bit counted;
        rst_n               = 1'b0;
        phase               = 0;
        req_ch.valid        = 1'b0;
        req_ch.action       = ACT_PUSH;
        req_ch.thread_id    = '0;
        req_ch.priority_req = '0;
        req_ch.cpu_id       = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part.
        // Pop on an empty queue.
        send_beat(ACT_POP,   6'd0,  5'd0,  3'd0);
        // Lowest and highest thread at lowest and highest level.
        send_beat(ACT_PUSH,  6'd0,  5'd0,  3'd0);
        send_beat(ACT_PUSH,  6'd63, 5'd31, 3'd7);
        // Push of a queued thread: ignored, entry stays at level 31.
        send_beat(ACT_PUSH,  6'd63, 5'd5,  3'd0);
        send_beat(ACT_PUSH,  6'd5,  5'd31, 3'd0);
        // Block a queued thread, then block one that was never ready.
        send_beat(ACT_BLOCK, 6'd63, 5'd0,  3'd0);
        send_beat(ACT_BLOCK, 6'd7,  5'd0,  3'd0);
        // Unused action with all fields at their top values.
        send_beat(ACT_NOP,   6'd63, 5'd31, 3'd7);
        // Pop drops stale 63, returns 5 at level 31, never ran.
        send_beat(ACT_POP,   6'd0,  5'd0,  3'd7);
        // 63 was dropped from its queue, so a new push appends it again.
        send_beat(ACT_PUSH,  6'd63, 5'd17, 3'd0);
        send_beat(ACT_POP,   6'd0,  5'd0,  3'd7);
        // Affinity: same CPU, then other CPU.
        send_beat(ACT_PUSH,  6'd5,  5'd20, 3'd0);
        send_beat(ACT_POP,   6'd0,  5'd0,  3'd7);
        send_beat(ACT_PUSH,  6'd5,  5'd20, 3'd0);
        send_beat(ACT_POP,   6'd0,  5'd0,  3'd0);
        // Stale head at level 0 skipped in favor of the next entry.
        send_beat(ACT_PUSH,  6'd1,  5'd0,  3'd0);
        send_beat(ACT_BLOCK, 6'd0,  5'd0,  3'd0);
        send_beat(ACT_POP,   6'd0,  5'd0,  3'd3);
        // Block then push while still queued: ready again, status already queued.
        send_beat(ACT_PUSH,  6'd2,  5'd9,  3'd0);
        send_beat(ACT_BLOCK, 6'd2,  5'd0,  3'd0);
        send_beat(ACT_PUSH,  6'd2,  5'd9,  3'd0);
        send_beat(ACT_POP,   6'd0,  5'd0,  3'd4);
        // Two more pops on a queue that is already empty.
        send_beat(ACT_POP,   6'd0,  5'd0,  3'd4);
        send_beat(ACT_POP,   6'd0,  5'd0,  3'd4);

        // Random part, one stretch per idling phase.
        for (stage = 0; stage < 3; stage++)
        begin
            phase  = stage;
            issued = 0;
            while (issued < BEATS_PER_PHASE)
            begin
                send_random_beat(counted);
                if (counted)
                    issued++;
            end
        end
        req_ch.valid = 1'b0;

        // Wait for every pending result, then let the block settle.
        while (picks_outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
